// ===== design/odith_pkg.sv =====
`default_nettype none

package odith_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int COMP_W = 8;
    localparam int COMP_FULL = (1 << COMP_W) - 1;
    localparam int NUM_CHAN = 4;

    // Rescale divides by (2^depth - 1) through a reciprocal multiply.
    localparam int RESC_SHIFT = 22;
    localparam int KEPT_W = COMP_W - 1;
    localparam int RESC_MUL_W = 30;
    localparam int RESC_PROD_W = KEPT_W + RESC_MUL_W;
    localparam int ALIGN_W = 23;

    localparam int unsigned RESC_MUL_D1 = COMP_FULL * (((2 ** RESC_SHIFT) + 1 - 1) / 1);
    localparam int unsigned RESC_MUL_D2 = COMP_FULL * (((2 ** RESC_SHIFT) + 3 - 1) / 3);
    localparam int unsigned RESC_MUL_D3 = COMP_FULL * (((2 ** RESC_SHIFT) + 7 - 1) / 7);
    localparam int unsigned RESC_MUL_D4 = COMP_FULL * (((2 ** RESC_SHIFT) + 15 - 1) / 15);
    localparam int unsigned RESC_MUL_D5 = COMP_FULL * (((2 ** RESC_SHIFT) + 31 - 1) / 31);
    localparam int unsigned RESC_MUL_D6 = COMP_FULL * (((2 ** RESC_SHIFT) + 63 - 1) / 63);
    localparam int unsigned RESC_MUL_D7 = COMP_FULL * (((2 ** RESC_SHIFT) + 127 - 1) / 127);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        REG_TARGET_DEPTH   = 3'd0,
        REG_MATRIX_ORDER   = 3'd1,
        REG_MATRIX_BITS    = 3'd2,
        REG_CHANNEL_ENABLE = 3'd3,
        REG_SRC_POS        = 3'd4,
        REG_DST_POS        = 3'd5
    } cfg_reg_t;

    // Settings derived from the configuration registers.
    typedef struct packed {
        logic [3:0] depth;
        logic [4:0] order;
        logic [3:0] mbits;
        logic       dither;
    } dcfg_t;

    function automatic logic [RESC_MUL_W-1:0] resc_mul(input logic [3:0] depth);
        logic [RESC_MUL_W-1:0] mul;
        unique case (depth)
            4'd1:    mul = RESC_MUL_W'(RESC_MUL_D1);
            4'd2:    mul = RESC_MUL_W'(RESC_MUL_D2);
            4'd3:    mul = RESC_MUL_W'(RESC_MUL_D3);
            4'd4:    mul = RESC_MUL_W'(RESC_MUL_D4);
            4'd5:    mul = RESC_MUL_W'(RESC_MUL_D5);
            4'd6:    mul = RESC_MUL_W'(RESC_MUL_D6);
            4'd7:    mul = RESC_MUL_W'(RESC_MUL_D7);
            default: mul = '0;
        endcase
        return mul;
    endfunction

endpackage

`default_nettype wire

// ===== design/odith_coord_mod.sv =====
`default_nettype none

module odith_coord_mod #(
    parameter int MAX_ORDER = odith_pkg::MAX_ORDER_DEF,
    localparam int ORDER_W = $clog2(MAX_ORDER + 1),
    localparam int REM_W = $clog2(MAX_ORDER),
    localparam int ACC_W = REM_W + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ORDER_W-1:0]     order,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  odith_pkg::opcode_t     opcode,
    input  logic [7:0]             coef_index,
    input  logic [7:0]             coef_value,
    input  logic [15:0]            pixel_row,
    input  logic [15:0]            pixel_col,
    input  logic [31:0]            src_pixel,
    input  logic [31:0]            dst_pixel_old,
    input  logic                   s3_ready,
    output logic                   s2_valid,
    output odith_pkg::opcode_t     s2_opcode,
    output logic [7:0]             s2_coef_index,
    output logic [7:0]             s2_coef_value,
    output logic [REM_W-1:0]       s2_row_rem,
    output logic [REM_W-1:0]       s2_col_rem,
    output logic [31:0]            s2_src,
    output logic [31:0]            s2_dst
);

    // Eight restoring remainder steps, one per coordinate bit.
    function automatic logic [REM_W-1:0] mod_steps(
        input logic [REM_W-1:0]   rem_in,
        input logic [7:0]         bits,
        input logic [ORDER_W-1:0] div
    );
        logic [ACC_W-1:0] acc;
        logic [REM_W-1:0] rem;
        rem = rem_in;
        for (int i = 7; i >= 0; i--) begin
            acc = {rem, bits[i]};
            if (acc >= ACC_W'(div)) begin
                acc = acc - ACC_W'(div);
            end
            rem = acc[REM_W-1:0];
        end
        return rem;
    endfunction

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    odith_pkg::opcode_t   s1_opcode_reg;
    logic [7:0]           s1_coef_index_reg;
    logic [7:0]           s1_coef_value_reg;
    logic [7:0]           s1_row_lo_reg;
    logic [7:0]           s1_col_lo_reg;
    logic [REM_W-1:0]     s1_row_rem_reg;
    logic [REM_W-1:0]     s1_col_rem_reg;
    logic [REM_W-1:0]     s1_row_rem_next;
    logic [REM_W-1:0]     s1_col_rem_next;
    logic [31:0]          s1_src_reg;
    logic [31:0]          s1_dst_reg;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    odith_pkg::opcode_t   s2_opcode_reg;
    logic [7:0]           s2_coef_index_reg;
    logic [7:0]           s2_coef_value_reg;
    logic [REM_W-1:0]     s2_row_rem_reg;
    logic [REM_W-1:0]     s2_col_rem_reg;
    logic [REM_W-1:0]     s2_row_rem_next;
    logic [REM_W-1:0]     s2_col_rem_next;
    logic [31:0]          s2_src_reg;
    logic [31:0]          s2_dst_reg;

    logic                 s1_ready;
    logic                 s2_ready;

    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign item_ready = s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? item_valid : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s1_row_rem_next = mod_steps('0, pixel_row[15:8], order);
        s1_col_rem_next = mod_steps('0, pixel_col[15:8], order);
        s2_row_rem_next = mod_steps(s1_row_rem_reg, s1_row_lo_reg, order);
        s2_col_rem_next = mod_steps(s1_col_rem_reg, s1_col_lo_reg, order);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_opcode_reg     <= opcode;
            s1_coef_index_reg <= coef_index;
            s1_coef_value_reg <= coef_value;
            s1_row_lo_reg     <= pixel_row[7:0];
            s1_col_lo_reg     <= pixel_col[7:0];
            s1_row_rem_reg    <= s1_row_rem_next;
            s1_col_rem_reg    <= s1_col_rem_next;
            s1_src_reg        <= src_pixel;
            s1_dst_reg        <= dst_pixel_old;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_opcode_reg     <= s1_opcode_reg;
            s2_coef_index_reg <= s1_coef_index_reg;
            s2_coef_value_reg <= s1_coef_value_reg;
            s2_row_rem_reg    <= s2_row_rem_next;
            s2_col_rem_reg    <= s2_col_rem_next;
            s2_src_reg        <= s1_src_reg;
            s2_dst_reg        <= s1_dst_reg;
        end
    end

    assign s2_valid      = s2_valid_reg;
    assign s2_opcode     = s2_opcode_reg;
    assign s2_coef_index = s2_coef_index_reg;
    assign s2_coef_value = s2_coef_value_reg;
    assign s2_row_rem    = s2_row_rem_reg;
    assign s2_col_rem    = s2_col_rem_reg;
    assign s2_src        = s2_src_reg;
    assign s2_dst        = s2_dst_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("First stage dropped a beat while stalled.");

endmodule

`default_nettype wire

// ===== design/odith_thr_mem.sv =====
`default_nettype none

module odith_thr_mem #(
    parameter int MAX_ORDER = odith_pkg::MAX_ORDER_DEF,
    localparam int ORDER_W = $clog2(MAX_ORDER + 1),
    localparam int REM_W = $clog2(MAX_ORDER),
    localparam int DEPTH = MAX_ORDER * MAX_ORDER,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int IDX_W = REM_W + ORDER_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ORDER_W-1:0]   order,
    input  logic                 s2_valid,
    output logic                 s3_ready,
    input  odith_pkg::opcode_t   s2_opcode,
    input  logic [7:0]           s2_coef_index,
    input  logic [7:0]           s2_coef_value,
    input  logic [REM_W-1:0]     s2_row_rem,
    input  logic [REM_W-1:0]     s2_col_rem,
    input  logic [31:0]          s2_src,
    input  logic [31:0]          s2_dst,
    input  logic                 s4_ready,
    output logic                 s3_valid,
    output logic [31:0]          s3_src,
    output logic [31:0]          s3_dst,
    output logic [7:0]           s3_thr
);

    logic [7:0]        mem [DEPTH];
    logic [IDX_W-1:0]  idx_full;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_we;
    logic              is_load;

    logic              s3_valid_reg;
    logic              s3_valid_next;
    logic [31:0]       s3_src_reg;
    logic [31:0]       s3_dst_reg;
    logic [7:0]        s3_thr_reg;

    assign s3_ready = !s3_valid_reg || s4_ready;

    always_comb
    begin
        is_load  = (s2_opcode == odith_pkg::OP_LOAD);
        idx_full = IDX_W'(s2_row_rem) * IDX_W'(order) + IDX_W'(s2_col_rem);
        rd_addr  = idx_full[ADDR_W-1:0];
        wr_addr  = s2_coef_index[ADDR_W-1:0];
        mem_we   = s2_valid && is_load && s3_ready && ({1'b0, s2_coef_index} < 9'(DEPTH));
        s3_valid_next = s3_ready ? (s2_valid && !is_load) : s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= s2_coef_value;
        end
        if (s3_ready)
        begin
            s3_thr_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid)
        begin
            s3_src_reg <= s2_src;
            s3_dst_reg <= s2_dst;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_src   = s3_src_reg;
    assign s3_dst   = s3_dst_reg;
    assign s3_thr   = s3_thr_reg;

    a_load_ends: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid && is_load && s3_ready |=> !s3_valid_reg)
        else $error("A load beat went on past the threshold memory.");

endmodule

`default_nettype wire

// ===== design/odith_chan.sv =====
`default_nettype none

module odith_chan (
    input  odith_pkg::dcfg_t cfg,
    input  logic [7:0]       val,
    input  logic [7:0]       thr,
    output logic [7:0]       res
);

    logic [3:0]                           drop;
    logic [7:0]                           low_mask;
    logic [7:0]                           high_mask;
    logic [odith_pkg::ALIGN_W-1:0]        frac_al;
    logic [odith_pkg::ALIGN_W-1:0]        thr_al;
    logic                                 fill;
    logic [7:0]                           dith_val;
    logic [odith_pkg::KEPT_W-1:0]         kept;
    logic [odith_pkg::RESC_PROD_W-1:0]    prod;
    logic [7:0]                           resc_val;

    always_comb
    begin
        drop      = 4'(odith_pkg::COMP_W) - cfg.depth;
        low_mask  = 8'(odith_pkg::COMP_FULL) >> cfg.depth;
        high_mask = ~low_mask;

        // Bring the dropped fraction and the threshold to one precision.
        frac_al = odith_pkg::ALIGN_W'(val & low_mask);
        thr_al  = odith_pkg::ALIGN_W'(thr);
        if (drop > cfg.mbits)
        begin
            thr_al = thr_al << (drop - cfg.mbits);
        end
        else if (drop < cfg.mbits)
        begin
            frac_al = frac_al << (cfg.mbits - drop);
        end
        fill     = frac_al > thr_al;
        dith_val = (val & high_mask) | (fill ? low_mask : 8'h00);

        kept = odith_pkg::KEPT_W'(val >> drop);
        prod = odith_pkg::RESC_PROD_W'(kept)
             * odith_pkg::RESC_PROD_W'(odith_pkg::resc_mul(cfg.depth));
        resc_val = prod[odith_pkg::RESC_SHIFT + odith_pkg::COMP_W - 1 : odith_pkg::RESC_SHIFT];

        res = cfg.dither ? dith_val : resc_val;
    end

endmodule

`default_nettype wire

// ===== design/odith_quant.sv =====
`default_nettype none

module odith_quant (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  odith_pkg::dcfg_t                            cfg,
    input  logic [7:0]                                  src_pos,
    input  logic                                        s3_valid,
    output logic                                        s4_ready,
    input  logic [31:0]                                 s3_src,
    input  logic [31:0]                                 s3_dst,
    input  logic [7:0]                                  s3_thr,
    input  logic                                        s5_ready,
    output logic                                        s4_valid,
    output logic [31:0]                                 s4_dst,
    output logic [odith_pkg::NUM_CHAN-1:0][7:0]         s4_res
);

    logic [odith_pkg::NUM_CHAN-1:0][7:0] chan_val;
    logic [odith_pkg::NUM_CHAN-1:0][7:0] chan_res;

    logic                                s4_valid_reg;
    logic                                s4_valid_next;
    logic [31:0]                         s4_dst_reg;
    logic [odith_pkg::NUM_CHAN-1:0][7:0] s4_res_reg;

    assign s4_ready = !s4_valid_reg || s5_ready;

    always_comb
    begin
        for (int k = 0; k < odith_pkg::NUM_CHAN; k++)
        begin
            chan_val[k] = s3_src[{src_pos[2*k +: 2], 3'b000} +: 8];
        end
        s4_valid_next = s4_ready ? s3_valid : s4_valid_reg;
    end

    for (genvar k = 0; k < odith_pkg::NUM_CHAN; k++)
    begin : g_chan
        odith_chan u_chan (
            .cfg (cfg),
            .val (chan_val[k]),
            .thr (s3_thr),
            .res (chan_res[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid)
        begin
            s4_dst_reg <= s3_dst;
            s4_res_reg <= chan_res;
        end
    end

    assign s4_valid = s4_valid_reg;
    assign s4_dst   = s4_dst_reg;
    assign s4_res   = s4_res_reg;

    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !s5_ready |=> s4_valid_reg && $stable(s4_res_reg)
            && $stable(s4_dst_reg))
        else $error("Channel stage changed while stalled.");

endmodule

`default_nettype wire

// ===== design/ordered_dither_pixel.sv =====
`default_nettype none

// Ordered dither of up to four 8-bit channels of a 32-bit pixel. Load beats
// (opcode 0) write one threshold coefficient at coef_index and give no result;
// pixel beats (opcode 1) give one result beat with dst_pixel_old in which each
// enabled channel is replaced, channel 0 first so a later channel that targets
// the same byte wins. With a matrix order of 2 or more the threshold at
// (row mod order, col mod order) decides whether the dropped bits are set; with
// order 0 or 1 the kept bits are rescaled to full range, and a target depth of
// 8 passes the destination pixel through. The threshold memory is not cleared
// at reset, so every entry that pixels will address must be loaded first. The
// block takes one beat per clock, loads and pixels alike. A pixel's result
// passes five registered stages: the coordinate remainders take two stages
// of eight restoring steps each, then come the memory read, the per-channel
// quantizer and the output register. It stops accepting beats only when all
// five stages are full and the result is not being taken. Configuration
// registers may be written only while no beat is in flight.
module ordered_dither_pixel #(
    parameter int MAX_ORDER = odith_pkg::MAX_ORDER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        opcode,
    input  logic [7:0]  coef_index,
    input  logic [7:0]  coef_value,
    input  logic [15:0] pixel_row,
    input  logic [15:0] pixel_col,
    input  logic [31:0] src_pixel,
    input  logic [31:0] dst_pixel_old,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] dst_pixel_new
);

    localparam int ORDER_W = $clog2(MAX_ORDER + 1);
    localparam int REM_W = $clog2(MAX_ORDER);

    logic [3:0] target_depth_reg;
    logic [4:0] matrix_order_reg;
    logic [3:0] matrix_bits_reg;
    logic [3:0] channel_enable_reg;
    logic [7:0] src_pos_reg;
    logic [7:0] dst_pos_reg;

    odith_pkg::dcfg_t dcfg;
    logic [4:0]       order_sat;

    logic                                s2_valid;
    odith_pkg::opcode_t                  s2_opcode;
    logic [7:0]                          s2_coef_index;
    logic [7:0]                          s2_coef_value;
    logic [REM_W-1:0]                    s2_row_rem;
    logic [REM_W-1:0]                    s2_col_rem;
    logic [31:0]                         s2_src;
    logic [31:0]                         s2_dst;
    logic                                s3_ready;
    logic                                s3_valid;
    logic [31:0]                         s3_src;
    logic [31:0]                         s3_dst;
    logic [7:0]                          s3_thr;
    logic                                s4_ready;
    logic                                s4_valid;
    logic [31:0]                         s4_dst;
    logic [odith_pkg::NUM_CHAN-1:0][7:0] s4_res;
    logic                                s5_ready;

    logic        result_valid_reg;
    logic        result_valid_next;
    logic [31:0] dst_new_reg;
    logic [31:0] merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_depth_reg   <= 4'(odith_pkg::COMP_W);
            matrix_order_reg   <= '0;
            matrix_bits_reg    <= '0;
            channel_enable_reg <= '0;
            src_pos_reg        <= '0;
            dst_pos_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (odith_pkg::cfg_reg_t'(cfg_index))
                odith_pkg::REG_TARGET_DEPTH:   target_depth_reg   <= cfg_data[3:0];
                odith_pkg::REG_MATRIX_ORDER:   matrix_order_reg   <= cfg_data[4:0];
                odith_pkg::REG_MATRIX_BITS:    matrix_bits_reg    <= cfg_data[3:0];
                odith_pkg::REG_CHANNEL_ENABLE: channel_enable_reg <= cfg_data[3:0];
                odith_pkg::REG_SRC_POS:        src_pos_reg        <= cfg_data;
                odith_pkg::REG_DST_POS:        dst_pos_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (target_depth_reg == 4'd0)
        begin
            dcfg.depth = 4'd1;
        end
        else if (target_depth_reg > 4'(odith_pkg::COMP_W))
        begin
            dcfg.depth = 4'(odith_pkg::COMP_W);
        end
        else
        begin
            dcfg.depth = target_depth_reg;
        end
        order_sat   = (matrix_order_reg > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : matrix_order_reg;
        // The remainder steps need a nonzero divisor even in rescale mode.
        dcfg.order  = (order_sat == 5'd0) ? 5'd1 : order_sat;
        dcfg.mbits  = matrix_bits_reg;
        dcfg.dither = order_sat > 5'd1;
    end

    odith_coord_mod #(
        .MAX_ORDER (MAX_ORDER)
    ) u_coord_mod (
        .clk           (clk),
        .rst_n         (rst_n),
        .order         (dcfg.order[ORDER_W-1:0]),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (odith_pkg::opcode_t'(opcode)),
        .coef_index    (coef_index),
        .coef_value    (coef_value),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .src_pixel     (src_pixel),
        .dst_pixel_old (dst_pixel_old),
        .s3_ready      (s3_ready),
        .s2_valid      (s2_valid),
        .s2_opcode     (s2_opcode),
        .s2_coef_index (s2_coef_index),
        .s2_coef_value (s2_coef_value),
        .s2_row_rem    (s2_row_rem),
        .s2_col_rem    (s2_col_rem),
        .s2_src        (s2_src),
        .s2_dst        (s2_dst)
    );

    odith_thr_mem #(
        .MAX_ORDER (MAX_ORDER)
    ) u_thr_mem (
        .clk           (clk),
        .rst_n         (rst_n),
        .order         (dcfg.order[ORDER_W-1:0]),
        .s2_valid      (s2_valid),
        .s3_ready      (s3_ready),
        .s2_opcode     (s2_opcode),
        .s2_coef_index (s2_coef_index),
        .s2_coef_value (s2_coef_value),
        .s2_row_rem    (s2_row_rem),
        .s2_col_rem    (s2_col_rem),
        .s2_src        (s2_src),
        .s2_dst        (s2_dst),
        .s4_ready      (s4_ready),
        .s3_valid      (s3_valid),
        .s3_src        (s3_src),
        .s3_dst        (s3_dst),
        .s3_thr        (s3_thr)
    );

    odith_quant u_quant (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (dcfg),
        .src_pos  (src_pos_reg),
        .s3_valid (s3_valid),
        .s4_ready (s4_ready),
        .s3_src   (s3_src),
        .s3_dst   (s3_dst),
        .s3_thr   (s3_thr),
        .s5_ready (s5_ready),
        .s4_valid (s4_valid),
        .s4_dst   (s4_dst),
        .s4_res   (s4_res)
    );

    assign s5_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        merged = s4_dst;
        if (dcfg.depth != 4'(odith_pkg::COMP_W))
        begin
            for (int k = 0; k < odith_pkg::NUM_CHAN; k++)
            begin
                if (channel_enable_reg[k])
                begin
                    merged[{dst_pos_reg[2*k +: 2], 3'b000} +: 8] = s4_res[k];
                end
            end
        end
        result_valid_next = s5_ready ? s4_valid : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s4_valid)
        begin
            dst_new_reg <= merged;
        end
    end

    assign result_valid  = result_valid_reg;
    assign dst_pixel_new = dst_new_reg;

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid_reg && !result_ready)
        else $error("Input stalled although the result side is not blocked.");

endmodule

`default_nettype wire

// ===== test/ordered_dither_pixel_tb.sv =====
module ordered_dither_pixel_tb;

    localparam int MATRIX_ORDER = odith_pkg::MAX_ORDER_DEF;
    localparam int MATRIX_DEPTH = MATRIX_ORDER * MATRIX_ORDER;
    localparam int LONG_HOLD = 60;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 10;
    localparam int BEATS_PER_PHASE = 62;

    typedef struct packed {
        odith_pkg::opcode_t op;
        logic [7:0]         cidx;
        logic [7:0]         cval;
        logic [15:0]        row;
        logic [15:0]        col;
        logic [31:0]        src;
        logic [31:0]        dst;
    } dither_beat_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    odith_pkg::cfg_reg_t cfg_index;
    logic [7:0]          cfg_data;
    logic                item_valid;
    logic                item_ready;
    logic                result_valid;
    logic                result_ready;
    logic [31:0]         dst_pixel_new;
    dither_beat_t        cur_beat;

    logic [3:0] cur_depth;
    logic [4:0] cur_order;
    logic [3:0] cur_mbits;
    logic [3:0] cur_enable;
    logic [7:0] cur_src_pos;
    logic [7:0] cur_dst_pos;

    logic [7:0]   thresholds [MATRIX_DEPTH];
    bit           loaded [MATRIX_DEPTH];
    dither_beat_t beat_q [$];
    logic [31:0]  expected_px [$];
    logic [31:0]  px_want;

    int beats_sent = 0;
    int beats_taken = 0;
    int send_gap = 0;
    int results_taken = 0;
    int results_counted = 0;
    int recv_wait = 0;
    int recv_draw = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int errors = 0;
    int pixels_checked = 0;
    int loads_taken = 0;
    int configs_used = 0;

    ordered_dither_pixel i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (cur_beat.op),
        .coef_index    (cur_beat.cidx),
        .coef_value    (cur_beat.cval),
        .pixel_row     (cur_beat.row),
        .pixel_col     (cur_beat.col),
        .src_pixel     (cur_beat.src),
        .dst_pixel_old (cur_beat.dst),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .dst_pixel_new (dst_pixel_new)
    );

    always #4 clk = ~clk;

    function automatic int unsigned order_in_use();
        return (cur_order > 5'(MATRIX_ORDER)) ? MATRIX_ORDER : 32'(cur_order);
    endfunction

    function automatic logic [7:0] reduce_cpnt(logic [7:0] v, int unsigned depth,
                                               int unsigned order, logic [15:0] row,
                                               logic [15:0] col);
        int unsigned drop;
        int unsigned low_mask;
        int unsigned high_mask;
        int unsigned thr;
        int unsigned frac;
        int unsigned mbits;
        drop = 8 - depth;
        low_mask = (32'd1 << drop) - 1;
        high_mask = 32'hFF & ~low_mask;
        mbits = 32'(cur_mbits);
        if (order > 1)
        begin
            thr = 32'(thresholds[(32'(row) % order) * order + 32'(col) % order]);
            frac = 32'(v) & low_mask;
            if (drop > mbits)
                thr = thr << (drop - mbits);
            else if (drop < mbits)
                frac = frac << (mbits - drop);
            return 8'((32'(v) & high_mask) | ((frac > thr) ? low_mask : 32'd0));
        end
        return 8'(((32'(v) & high_mask) * 255) / high_mask);
    endfunction

    function automatic logic [31:0] dithered_pixel(dither_beat_t b);
        int unsigned depth;
        int unsigned order;
        int unsigned s_sh;
        int unsigned d_sh;
        logic [31:0] px;
        if (cur_depth == 4'd0)
            depth = 1;
        else if (cur_depth > 4'd8)
            depth = 8;
        else
            depth = 32'(cur_depth);
        order = order_in_use();
        px = b.dst;
        if (depth != 8)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (cur_enable[k])
                begin
                    s_sh = 32'(cur_src_pos[2*k +: 2]) * 8;
                    d_sh = 32'(cur_dst_pos[2*k +: 2]) * 8;
                    px[d_sh +: 8] = reduce_cpnt(b.src[s_sh +: 8], depth, order, b.row, b.col);
                end
            end
        end
        return px;
    endfunction

    function automatic dither_beat_t random_beat();
        dither_beat_t b;
        b.op = odith_pkg::OP_PIXEL;
        b.cidx = 8'($urandom);
        b.cval = 8'($urandom);
        b.row = 16'($urandom);
        b.col = 16'($urandom);
        b.src = $urandom;
        b.dst = $urandom;
        return b;
    endfunction

    task automatic write_reg(input odith_pkg::cfg_reg_t r, input logic [7:0] val);
        cfg_index <= r;
        cfg_data <= val;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        case (r)
            odith_pkg::REG_TARGET_DEPTH:   cur_depth = val[3:0];
            odith_pkg::REG_MATRIX_ORDER:   cur_order = val[4:0];
            odith_pkg::REG_MATRIX_BITS:    cur_mbits = val[3:0];
            odith_pkg::REG_CHANNEL_ENABLE: cur_enable = val[3:0];
            odith_pkg::REG_SRC_POS:        cur_src_pos = val;
            odith_pkg::REG_DST_POS:        cur_dst_pos = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] depth, input logic [7:0] order,
                                input logic [7:0] mbits, input logic [7:0] enable,
                                input logic [7:0] src_pos, input logic [7:0] dst_pos);
        write_reg(odith_pkg::REG_TARGET_DEPTH, depth);
        write_reg(odith_pkg::REG_MATRIX_ORDER, order);
        write_reg(odith_pkg::REG_MATRIX_BITS, mbits);
        write_reg(odith_pkg::REG_CHANNEL_ENABLE, enable);
        write_reg(odith_pkg::REG_SRC_POS, src_pos);
        write_reg(odith_pkg::REG_DST_POS, dst_pos);
        cfg_wr_en <= 1'b0;
        configs_used++;
    endtask

    task automatic queue_load(input logic [7:0] idx, input logic [7:0] val);
        dither_beat_t b;
        b = random_beat();
        b.op = odith_pkg::OP_LOAD;
        b.cidx = idx;
        b.cval = val;
        loaded[idx] = 1'b1;
        beat_q.push_back(b);
    endtask

    // A pixel in dither mode must never address an unloaded threshold, so one is loaded first.
    task automatic queue_pixel(input logic [15:0] row, input logic [15:0] col,
                               input logic [31:0] src, input logic [31:0] dst);
        dither_beat_t b;
        int unsigned order;
        int unsigned idx;
        order = order_in_use();
        if (order > 1)
        begin
            idx = (32'(row) % order) * order + 32'(col) % order;
            if (!loaded[idx])
                queue_load(8'(idx), 8'($urandom));
        end
        b = random_beat();
        b.row = row;
        b.col = col;
        b.src = src;
        b.dst = dst;
        beat_q.push_back(b);
    endtask

    task automatic drain();
        while (!(beat_q.size() == 0 && beats_taken == beats_sent && expected_px.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || beats_taken == beats_sent)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    cur_beat <= beat_q.pop_front();
                    item_valid <= 1'b1;
                    beats_sent <= beats_sent + 1;
                    send_gap <= (beats_sent % 100 < 30) ? 0 : int'($urandom_range(0, 5));
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                results_counted <= results_taken;
                recv_wait <= LONG_HOLD;
                result_ready <= 1'b0;
            end
            else if (results_taken != results_counted)
            begin
                results_counted <= results_taken;
                recv_draw = (results_taken % 64 < 20) ? 0 : int'($urandom_range(0, 5));
                result_ready <= (recv_draw == 0);
                recv_wait <= (recv_draw == 0) ? 0 : recv_draw - 1;
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_taken <= results_taken + 1;
                if (expected_px.size() == 0)
                begin
                    $display("%0t: dst_pixel_new %08h arrived with nothing expected",
                             $time, dst_pixel_new);
                    errors++;
                end
                else
                begin
                    px_want = expected_px.pop_front();
                    pixels_checked++;
                    if (dst_pixel_new !== px_want)
                    begin
                        $display("%0t: dst_pixel_new expected %08h, got %08h",
                                 $time, px_want, dst_pixel_new);
                        errors++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                beats_taken <= beats_taken + 1;
                if (cur_beat.op == odith_pkg::OP_LOAD)
                begin
                    thresholds[cur_beat.cidx] = cur_beat.cval;
                    loads_taken++;
                end
                else
                    expected_px.push_back(dithered_pixel(cur_beat));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int unsigned td;
        int unsigned mo;
        int unsigned mb;
        int unsigned en;
        int unsigned order;
        int unsigned idx;
        rst_n = 1'b0;
        item_valid = 1'b0;
        cur_beat = '0;
        cfg_wr_en = 1'b0;
        cfg_index = odith_pkg::REG_TARGET_DEPTH;
        cfg_data = 8'd0;
        result_ready = 1'b0;
        cur_depth = 4'd8;
        cur_order = 5'd0;
        cur_mbits = 4'd0;
        cur_enable = 4'd0;
        cur_src_pos = 8'd0;
        cur_dst_pos = 8'd0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        queue_pixel(16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h1234_5678);
        drain();
        program_regs(8'd8, 8'd0, 8'd0, 8'd15, 8'hE4, 8'hE4);
        queue_pixel(16'hFFFF, 16'hFFFF, 32'h00FF_7F80, 32'hDEAD_BEEF);
        drain();
        program_regs(8'd1, 8'd0, 8'd0, 8'd15, 8'hE4, 8'h1B);
        queue_pixel(16'h0001, 16'h8000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_pixel(16'h8000, 16'h0001, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_pixel(16'h5555, 16'hAAAA, 32'h8040_7F01, 32'h55AA_55AA);
        drain();
        program_regs(8'd7, 8'd1, 8'd8, 8'd15, 8'hE4, 8'hE4);
        queue_pixel(16'hAAAA, 16'h5555, 32'hA5A5_A5A5, 32'h0000_0000);
        queue_pixel(16'h0000, 16'hFFFF, 32'h01FE_7F80, 32'hFFFF_FFFF);
        drain();
        program_regs(8'd0, 8'd1, 8'd0, 8'd5, 8'h1B, 8'hE4);
        queue_pixel(16'($urandom), 16'($urandom), $urandom, $urandom);
        drain();
        program_regs(8'd15, 8'd1, 8'd0, 8'd15, 8'hE4, 8'h4E);
        queue_pixel(16'($urandom), 16'($urandom), $urandom, $urandom);
        drain();
        program_regs(8'd2, 8'd2, 8'd2, 8'd15, 8'hE4, 8'hE4);
        queue_load(8'd0, 8'd0);
        queue_load(8'd1, 8'd255);
        queue_load(8'd2, 8'd1);
        queue_load(8'd3, 8'd2);
        queue_pixel(16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_pixel(16'h0000, 16'h0001, 32'h3F3F_2A15, 32'hFFFF_FFFF);
        queue_pixel(16'hFFFF, 16'hFFFF, 32'h0102_0300, 32'h8080_8080);
        drain();
        program_regs(8'd1, 8'd31, 8'd15, 8'd15, 8'hE4, 8'hE4);
        queue_load(8'd255, 8'd255);
        queue_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_pixel(16'h0010, 16'h0020, 32'h7F7F_7F7F, 32'hFFFF_FFFF);
        drain();
        program_regs(8'd7, 8'd16, 8'd0, 8'd15, 8'hE4, 8'hE4);
        queue_pixel(16'hFFFF, 16'h0000, 32'h0303_0101, 32'h0000_0000);
        drain();
        program_regs(8'd4, 8'd0, 8'd0, 8'd15, 8'hE4, 8'h00);
        queue_pixel(16'h0000, 16'h0000, 32'h1234_56F8, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            td = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 7);
            mo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 8);
            mb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
            en = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 15);
            program_regs(8'(td), 8'(mo), 8'(mb), 8'(en), 8'($urandom), 8'($urandom));
            order = order_in_use();
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    if (order > 1 && $urandom_range(0, 1) == 0)
                        idx = $urandom_range(0, order * order - 1);
                    else
                        idx = $urandom_range(0, MATRIX_DEPTH - 1);
                    queue_load(8'(idx), 8'($urandom));
                end
                else
                    queue_pixel(($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom),
                                ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom),
                                $urandom, $urandom);
            end
            if (ph == 2)
                hold_req = hold_req + 1;
            drain();
        end

        $display("Checked %0d pixel results and %0d threshold loads over %0d register settings,",
                 pixels_checked, loads_taken, configs_used);
        $display("covering rescale, dither, pass-through and a long output stall.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
